FILE: src/wvpc_pkg.sv
`timescale 1ns / 1ps
package wvpc_pkg;

  localparam int FieldW = 24;
  localparam int DefMaxWindow = 128;
  localparam int DefFracBits = 8;
  localparam logic [7:0] DefaultWindow = 8'd96;
  localparam logic [15:0] ScoreMax = 16'd40960;

  typedef struct packed {
    logic [FieldW-1:0] bar_high;
    logic [FieldW-1:0] bar_low;
    logic [FieldW-1:0] bar_close;
    logic [FieldW-1:0] bar_volume;
  } bar_t;

  typedef struct packed {
    logic [15:0] marker_size;
    logic        score_valid;
  } score_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_READ, ST_ACC, ST_DIV_V, ST_DIST, ST_DIV_S, ST_DONE
  } back_state_t;

endpackage

FILE: src/wvpc_queue.sv
`timescale 1ns / 1ps
module wvpc_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  wvpc_pkg::bar_t   in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output wvpc_pkg::bar_t   out_data
);
  import wvpc_pkg::*;

  bar_t       slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign in_ready  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_data  = slot[rd_ptr];

  // store incoming bars
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      slot[wr_ptr] <= in_data;
    end
  end

  // advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (in_valid && in_ready) wr_ptr <= ~wr_ptr;
      if (out_valid && out_ready) rd_ptr <= ~rd_ptr;
      count <= count + 2'(in_valid && in_ready) - 2'(out_valid && out_ready);
    end
  end

endmodule

FILE: src/wvpc_divider.sv
`timescale 1ns / 1ps
module wvpc_divider #(
  parameter int NumW = 72,
  parameter int DenW = 34
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [NumW-1:0] num,
  input  logic [DenW-1:0] den,
  output logic            busy,
  output logic [NumW-1:0] quot
);
  localparam int CntW = $clog2(NumW + 1);

  logic [NumW-1:0] q;
  logic [DenW:0]   rem;
  logic [DenW-1:0] d;
  logic [CntW-1:0] left;
  logic [DenW:0]   trial;
  logic [DenW:0]   shifted;

  assign shifted = {rem[DenW-1:0], q[NumW-1]};
  assign trial   = shifted - {1'b0, d};
  assign quot    = q;
  assign busy    = (left != '0);

  // one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      left <= '0;
    end else if (start) begin
      left <= CntW'(NumW);
    end else if (busy) begin
      left <= left - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q   <= num;
      rem <= '0;
      d   <= den;
    end else if (busy) begin
      if (!trial[DenW]) begin
        rem <= trial;
        q   <= {q[NumW-2:0], 1'b1};
      end else begin
        rem <= shifted;
        q   <= {q[NumW-2:0], 1'b0};
      end
    end
  end

endmodule

FILE: src/wvpc_back.sv
`timescale 1ns / 1ps
module wvpc_back #(
  parameter int MaxWindow = wvpc_pkg::DefMaxWindow,
  parameter int FracBits  = wvpc_pkg::DefFracBits
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [7:0]       window_len,
  input  logic             bar_valid,
  output logic             bar_ready,
  input  wvpc_pkg::bar_t   bar,
  output logic             res_valid,
  input  logic             res_ready,
  output wvpc_pkg::score_t res
);
  import wvpc_pkg::*;

  localparam int AddrW = $clog2(MaxWindow);
  localparam int CntW  = $clog2(MaxWindow + 1);
  localparam int WinW  = (CntW > 8) ? CntW : 8;
  localparam int VsumW = FieldW + CntW;
  localparam int NumW  = 2 * FieldW + 2 + CntW;
  localparam int DenW  = VsumW + 2;
  localparam int QW    = (NumW > 16 + 3 + FracBits) ? NumW : 16 + 3 + FracBits;
  localparam logic [QW-1:0] ScoreNum = QW'(40960) << FracBits;
  localparam int PivShift = FieldW + 3;
  localparam logic [PivShift-1:0] PivRecip =
    PivShift'(((64'd1 << PivShift) + 64'd2) / 64'd3);

  logic [FieldW-1:0] high_ring   [MaxWindow];
  logic [FieldW-1:0] low_ring    [MaxWindow];
  logic [FieldW-1:0] close_ring  [MaxWindow];
  logic [FieldW-1:0] volume_ring [MaxWindow];

  back_state_t state, state_next;
  logic [AddrW-1:0] write_slot;
  logic [AddrW-1:0] newest;
  logic [AddrW-1:0] rd_addr;
  logic [CntW-1:0]  bars_seen;
  logic [CntW-1:0]  n_left;
  logic             rd_live;
  logic [FieldW-1:0] rh, rl, rc, rv;
  logic [NumW-1:0]  num;
  logic [VsumW-1:0] vsum;
  logic [FieldW-1:0] hmax, lmin, cl;
  logic [FieldW+1:0] vwap, pivot;
  logic [FieldW+2:0] dev_sum;
  logic [CntW-1:0]  win;
  logic [WinW-1:0]  win_req;
  logic             div_start, div_busy;
  logic [QW-1:0]    div_num, div_q;
  logic [DenW-1:0]  div_den;
  logic [FieldW+1:0] piv_sum;
  logic [2*PivShift-1:0] piv_prod;
  logic [FieldW+1:0] d1, d2;

  assign bar_ready = (state == ST_IDLE);

  // effective window length
  always_comb begin
    win_req = (window_len < 8'd2) ? WinW'(DefaultWindow) : WinW'(window_len);
    win = (win_req > WinW'(bars_seen)) ? bars_seen : win_req[CntW-1:0];
  end

  // ring write and registered ring read
  always_ff @(posedge clk) begin
    if (bar_valid && bar_ready) begin
      high_ring[write_slot]   <= bar.bar_high;
      low_ring[write_slot]    <= bar.bar_low;
      close_ring[write_slot]  <= bar.bar_close;
      volume_ring[write_slot] <= bar.bar_volume;
    end
    rh <= high_ring[rd_addr];
    rl <= low_ring[rd_addr];
    rc <= close_ring[rd_addr];
    rv <= volume_ring[rd_addr];
  end

  assign piv_sum = (FieldW+2)'(hmax) + (FieldW+2)'(lmin) + (FieldW+2)'(cl);
  // divide by three through a reciprocal multiply
  assign piv_prod = (2*PivShift)'(piv_sum) * (2*PivShift)'(PivRecip);
  assign d1 = ((FieldW+2)'(cl) >= vwap) ? (FieldW+2)'(cl) - vwap : vwap - (FieldW+2)'(cl);
  assign d2 = ((FieldW+2)'(cl) >= pivot) ? (FieldW+2)'(cl) - pivot
                                          : pivot - (FieldW+2)'(cl);

  // sequence the window walk and both divisions
  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    div_num    = QW'(num);
    div_den    = DenW'(vsum) + (DenW'(vsum) << 1);
    unique case (state)
      ST_IDLE:  if (bar_valid) state_next = ST_READ;
      ST_READ:  state_next = (bars_seen < CntW'(3)) ? ST_DONE : ST_ACC;
      ST_ACC: begin
        if (n_left == '0 && !rd_live) begin
          state_next = ST_DIV_V;
          div_start  = (vsum != '0);
        end
      end
      ST_DIV_V: begin
        if (!div_busy) state_next = ST_DIST;
      end
      ST_DIST: begin
        state_next = ST_DIV_S;
        div_start  = 1'b1;
        div_num    = ScoreNum;
        div_den    = DenW'(dev_sum) + (DenW'(1) << FracBits);
      end
      ST_DIV_S: begin
        div_num = ScoreNum;
        div_den = DenW'(dev_sum) + (DenW'(1) << FracBits);
        if (!div_busy && !div_start) state_next = ST_DONE;
      end
      ST_DONE:  if (res_ready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      write_slot <= '0;
      bars_seen  <= '0;
      rd_live    <= 1'b0;
      n_left     <= '0;
    end else begin
      state <= state_next;
      if (bar_valid && bar_ready) begin
        newest     <= write_slot;
        write_slot <= (write_slot == AddrW'(MaxWindow - 1)) ? '0 : write_slot + 1'b1;
        if (bars_seen != CntW'(MaxWindow)) bars_seen <= bars_seen + 1'b1;
      end
      rd_live <= 1'b0;
      if (state == ST_READ) begin
        n_left  <= win;
        rd_addr <= newest;
        num     <= '0;
        vsum    <= '0;
        hmax    <= '0;
        lmin    <= '1;
        cl      <= '0;
      end
      if (state == ST_ACC) begin
        // issue one ring read per cycle
        if (n_left != '0) begin
          n_left  <= n_left - 1'b1;
          rd_addr <= (rd_addr == '0) ? AddrW'(MaxWindow - 1) : rd_addr - 1'b1;
          rd_live <= 1'b1;
          if (n_left == win) cl <= close_ring[newest];
        end
        // accumulate the entry read last cycle
        if (rd_live) begin
          num  <= num + NumW'((FieldW+2)'(rh) + (FieldW+2)'(rl) + (FieldW+2)'(rc))
                      * NumW'(rv);
          vsum <= vsum + VsumW'(rv);
          if (rh > hmax) hmax <= rh;
          if (rl < lmin) lmin <= rl;
        end
      end
      if (state == ST_DIV_V && !div_busy) begin
        vwap  <= (vsum != '0) ? (FieldW+2)'(div_q) : (FieldW+2)'(cl);
        pivot <= piv_prod[PivShift +: FieldW+2];
      end
      if (state == ST_DIV_S && !div_busy && !div_start) begin
        res.score_valid <= 1'b1;
        res.marker_size <= (div_q > QW'(ScoreMax)) ? ScoreMax : div_q[15:0];
      end
      if (state == ST_READ && bars_seen < CntW'(3)) begin
        res.score_valid <= 1'b0;
        res.marker_size <= '0;
      end
    end
  end

  assign dev_sum = (FieldW+3)'(d1) + (FieldW+3)'(d2);
  assign res_valid = (state == ST_DONE);

  wvpc_divider #(.NumW(QW), .DenW(DenW)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .quot  (div_q)
  );

endmodule

FILE: src/windowed_vwap_pivot_confluence.sv
`timescale 1ns / 1ps
// Rolling VWAP / pivot confluence score.
// in channel: one bar (high, low, close, volume) per transfer, valid/ready.
// out channel: one score (marker_size, score_valid) per bar, valid/ready.
// window_len is written through window_len_we/window_len_wd; the user
// writes it only while idle, which the block itself does not enforce.
// A two-entry queue takes bars while the back end works. The back end
// walks the window one ring entry per cycle (up to 128), then runs two
// bit-serial divisions (only the second when the window volume is zero,
// none while fewer than three bars are seen).
// The score is held in an output register until the receiver takes it;
// a stalled receiver stops the back end, and the queue then fills.
// Synchronous reset empties the queue, zeroes the bar count and write
// slot and sets window_len to 96. Ring contents are not cleared.
module windowed_vwap_pivot_confluence #(
  parameter int MaxWindow = wvpc_pkg::DefMaxWindow,
  parameter int FracBits  = wvpc_pkg::DefFracBits
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             window_len_we,
  input  logic [7:0]       window_len_wd,
  input  logic             in_valid,
  output logic             in_ready,
  input  wvpc_pkg::bar_t   in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output wvpc_pkg::score_t out_data
);
  import wvpc_pkg::*;

  logic [7:0] window_len;
  logic       q_valid, q_ready;
  bar_t       q_data;

  // hold the window register
  always_ff @(posedge clk) begin
    if (rst) begin
      window_len <= DefaultWindow;
    end else if (window_len_we) begin
      window_len <= window_len_wd;
    end
  end

  wvpc_queue u_queue (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(q_valid), .out_ready(q_ready), .out_data(q_data)
  );

  wvpc_back #(.MaxWindow(MaxWindow), .FracBits(FracBits)) u_back (
    .clk(clk), .rst(rst), .window_len(window_len),
    .bar_valid(q_valid), .bar_ready(q_ready), .bar(q_data),
    .res_valid(out_valid), .res_ready(out_ready), .res(out_data)
  );

`ifndef SYNTHESIS
  a_score_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.marker_size <= ScoreMax) else $error("score range");
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.score_valid) |-> out_data.marker_size == 16'd0)
    else $error("invalid score nonzero");
`endif

endmodule
